/* hw/rtl/mpt_pkg.sv */
package mpt_pkg;

	localparam logic [1:0] ACT_REGISTER = 2'd0;
	localparam logic [1:0] ACT_YIELD    = 2'd1;
	localparam logic [1:0] ACT_RENICE   = 2'd2;
	localparam logic [1:0] ACT_SLEEP    = 2'd3;

	localparam logic [1:0] ST_SUSPENDED = 2'd0;
	localparam logic [1:0] ST_RUNNING   = 2'd1;
	localparam logic [1:0] ST_COMPLETED = 2'd2;
	localparam logic [1:0] ST_SLEEP     = 2'd3;

	localparam logic [2:0] POL_DEFAULT  = 3'd0;
	localparam logic [2:0] POL_FIFO     = 3'd1;
	localparam logic [2:0] POL_LIFO     = 3'd2;
	localparam logic [2:0] POL_SJF      = 3'd3;
	localparam logic [2:0] POL_PRIORITY = 3'd4;
	localparam logic [2:0] POL_RATE     = 3'd5;
	localparam logic [2:0] POL_DEADLINE = 3'd6;
	localparam logic [2:0] POL_INVALID  = 3'd7;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_NOTSK = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic        has_info;
		logic [2:0]  task_policy;
		logic [15:0] exec_burst;
		logic [15:0] priority_value;
		logic [15:0] frequency;
		logic [15:0] deadline;
		logic [3:0]  task_index;
		logic        sleep_flag;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  next_task;
		logic [15:0] current_priority;
		logic [31:0] run_count;
		logic [4:0]  task_count;
	} result_t;

	typedef struct packed {
		logic [2:0]  policy;
		logic [15:0] burst;
		logic [15:0] prio;
		logic [15:0] freq;
		logic [15:0] dline;
		logic [31:0] runs;
	} entry_t;

	function automatic logic [15:0] key_of(entry_t e, logic [2:0] pol);
		logic [15:0] k;
		case (pol)
			POL_SJF:      k = e.burst;
			POL_PRIORITY: k = e.prio;
			POL_RATE:     k = e.freq;
			default:      k = e.dline;
		endcase
		return k;
	endfunction

	function automatic logic eligible(logic [1:0] s);
		return (s != ST_SLEEP) && (s != ST_COMPLETED);
	endfunction

endpackage

/* hw/rtl/multi_policy_task_picker_top.sv */
// Task picker over a table of up to MAX_TASKS entries. Raise start for one cycle while busy is
// low to transfer a command; exactly one result follows, shown for a single cycle with done
// high, and it cannot be held off, so the receiver must take it then. Register, sleep-mark and
// rejected commands go straight to the output state; renice reads the current entry and writes
// its new priority. A yield reads the current entry and, unless its policy is invalid, checks
// every entry for completion one per cycle, then scans again one entry per cycle, reading the
// attribute memory through its single read port for the minimum-key policies, and finishes with
// a read-modify-write of the chosen entry.
module multi_policy_task_picker_top #(
	parameter int MAX_TASKS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  mpt_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done,
	output mpt_pkg::result_t result
);
	import mpt_pkg::*;

	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int EW = $bits(entry_t);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_RDCUR = 11'b00000000010,
		S_POL   = 11'b00000000100,
		S_CHK   = 11'b00000001000,
		S_FWD   = 11'b00000010000,
		S_BWD   = 11'b00000100000,
		S_MIN   = 11'b00001000000,
		S_RDNXT = 11'b00010000000,
		S_WRNXT = 11'b00100000000,
		S_OUT   = 11'b01000000000,
		S_SPARE = 11'b10000000000
	} fsm_t;

	fsm_t          fsm_q;
	cmd_t          cmd_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] cur_q, c_q, last_q, nxt_q, m_idx_q, best_q;
	logic [CW-1:0] iss_q;
	logic          found_q, alld_q, m_vld_q, done_q;
	logic [2:0]    pol_q;
	logic [1:0]    sts_q;
	logic [15:0]   bkey_q, sh_prio_q;
	logic [31:0]   sh_runs_q;
	logic [1:0]    st_q [MAX_TASKS];
	result_t       res_q;

	logic          we;
	logic [IW-1:0] waddr, raddr, sidx;
	entry_t        wdata, rdata;
	logic [EW-1:0] rbits;
	logic [1:0]    st_rd;
	logic [IW-1:0] cur_inc, cur_dec, c_inc, c_dec, last_idx;
	logic [15:0]   mkey;

	assign rdata = entry_t'(rbits);

	mpt_ram #(.WIDTH(EW), .DEPTH(MAX_TASKS)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rbits)
	);

	assign last_idx = IW'(cnt_q - CW'(1));
	assign cur_inc  = (cur_q == last_idx) ? '0 : cur_q + IW'(1);
	assign cur_dec  = (cur_q == '0) ? last_idx : cur_q - IW'(1);
	assign c_inc    = (c_q == last_idx) ? '0 : c_q + IW'(1);
	assign c_dec    = (c_q == '0) ? last_idx : c_q - IW'(1);
	assign sidx     = (fsm_q == S_MIN) ? m_idx_q : c_q;
	assign st_rd    = st_q[sidx];
	assign mkey     = key_of(rdata, pol_q);

	always_comb begin
		we    = 1'b0;
		waddr = cur_q;
		wdata = rdata;
		raddr = cur_q;
		unique case (fsm_q)
			S_IDLE: begin
				waddr = IW'(cnt_q);
				wdata.policy = cmd.has_info ? cmd.task_policy : POL_DEFAULT;
				wdata.burst  = cmd.has_info ? cmd.exec_burst : 16'd0;
				wdata.prio   = cmd.has_info ? cmd.priority_value : 16'd0;
				wdata.freq   = cmd.has_info ? cmd.frequency : 16'd0;
				wdata.dline  = cmd.has_info ? cmd.deadline : 16'd0;
				wdata.runs   = 32'd0;
				we = start && (cmd.action == ACT_REGISTER) && (cnt_q < CW'(MAX_TASKS));
			end
			S_POL: begin
				wdata.prio = cmd_q.priority_value;
				we = (cmd_q.action == ACT_RENICE);
			end
			S_MIN:   raddr = IW'(iss_q);
			S_RDNXT: raddr = nxt_q;
			S_WRNXT: begin
				waddr = nxt_q;
				wdata.runs = rdata.runs + 32'd1;
				we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q     <= S_IDLE;
			cnt_q     <= '0;
			cur_q     <= '0;
			done_q    <= 1'b0;
			m_vld_q   <= 1'b0;
			found_q   <= 1'b0;
			sh_prio_q <= '0;
			sh_runs_q <= '0;
			for (int i = 0; i < MAX_TASKS; i++) begin
				st_q[i] <= ST_SUSPENDED;
			end
		end else begin
			done_q <= 1'b0;
			unique case (fsm_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						sts_q <= STS_OK;
						fsm_q <= S_OUT;
						unique case (cmd.action)
							ACT_REGISTER: begin
								if (cnt_q >= CW'(MAX_TASKS)) begin
									sts_q <= STS_FULL;
								end else begin
									st_q[IW'(cnt_q)] <= ST_SUSPENDED;
									cnt_q <= cnt_q + CW'(1);
									if (IW'(cnt_q) == cur_q) begin
										sh_prio_q <= wdata.prio;
										sh_runs_q <= 32'd0;
									end
								end
							end
							ACT_YIELD, ACT_RENICE: begin
								if (cnt_q == '0) begin
									sts_q <= STS_NOTSK;
								end else begin
									fsm_q <= S_RDCUR;
								end
							end
							ACT_SLEEP: begin
								if ((CW + 4)'(cmd.task_index) >= (CW + 4)'(cnt_q)) begin
									sts_q <= STS_NOTSK;
								end else begin
									st_q[IW'(cmd.task_index)] <= cmd.sleep_flag ?
										ST_SLEEP : ST_SUSPENDED;
								end
							end
							default: ;
						endcase
					end
				end
				S_RDCUR: fsm_q <= S_POL;
				S_POL: begin
					pol_q <= rdata.policy;
					if (cmd_q.action == ACT_RENICE) begin
						sh_prio_q <= cmd_q.priority_value;
						fsm_q <= S_OUT;
					end else if (rdata.policy == POL_INVALID) begin
						fsm_q <= S_OUT;
					end else begin
						st_q[cur_q] <= ST_COMPLETED;
						c_q    <= '0;
						alld_q <= 1'b1;
						fsm_q  <= S_CHK;
					end
				end
				S_CHK: begin
					if (c_q == last_idx) begin
						if (alld_q && (st_rd == ST_COMPLETED)) begin
							for (int i = 0; i < MAX_TASKS; i++) begin
								if ((CW'(i) < cnt_q) && (st_q[i] != ST_SLEEP)) begin
									st_q[i] <= ST_SUSPENDED;
								end
							end
						end
						found_q <= 1'b0;
						m_vld_q <= 1'b0;
						iss_q   <= '0;
						if (pol_q == POL_DEFAULT || pol_q == POL_FIFO) begin
							c_q   <= cur_inc;
							fsm_q <= S_FWD;
						end else if (pol_q == POL_LIFO) begin
							c_q   <= cur_dec;
							fsm_q <= S_BWD;
						end else begin
							fsm_q <= S_MIN;
						end
					end else begin
						if (st_rd != ST_COMPLETED) begin
							alld_q <= 1'b0;
						end
						c_q <= c_q + IW'(1);
					end
				end
				S_FWD: begin
					if ((c_inc == cur_q) || eligible(st_rd)) begin
						nxt_q <= c_q;
						fsm_q <= S_RDNXT;
					end else begin
						c_q <= c_inc;
					end
				end
				S_BWD: begin
					if (c_q == cur_q) begin
						nxt_q <= found_q ? last_q : '0;
						fsm_q <= S_RDNXT;
					end else if (eligible(st_rd)) begin
						nxt_q <= c_q;
						fsm_q <= S_RDNXT;
					end else begin
						last_q  <= c_q;
						found_q <= 1'b1;
						c_q     <= c_dec;
					end
				end
				S_MIN: begin
					if (iss_q < cnt_q) begin
						m_vld_q <= 1'b1;
						m_idx_q <= IW'(iss_q);
						iss_q   <= iss_q + CW'(1);
					end else begin
						m_vld_q <= 1'b0;
					end
					if (m_vld_q && (m_idx_q != cur_q) && eligible(st_rd) &&
					    (!found_q || (mkey < bkey_q))) begin
						found_q <= 1'b1;
						best_q  <= m_idx_q;
						bkey_q  <= mkey;
					end
					if ((iss_q == cnt_q) && !m_vld_q) begin
						nxt_q <= found_q ? best_q : '0;
						fsm_q <= S_RDNXT;
					end
				end
				S_RDNXT: fsm_q <= S_WRNXT;
				S_WRNXT: begin
					st_q[nxt_q] <= ST_RUNNING;
					cur_q       <= nxt_q;
					sh_prio_q   <= rdata.prio;
					sh_runs_q   <= rdata.runs + 32'd1;
					fsm_q       <= S_OUT;
				end
				S_OUT: begin
					res_q.status           <= sts_q;
					res_q.next_task        <= 4'(cur_q);
					res_q.current_priority <= (cnt_q == '0) ? 16'd0 : sh_prio_q;
					res_q.run_count        <= (cnt_q == '0) ? 32'd0 : sh_runs_q;
					res_q.task_count       <= 5'(cnt_q);
					done_q <= 1'b1;
					fsm_q  <= S_IDLE;
				end
				default: fsm_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (fsm_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("Result strobe held for more than one cycle.");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_TASKS)) else $error("Task count beyond table size.");
	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> (CW'(cur_q) < cnt_q)) else $error("Current task outside table.");
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("Transfer not followed by busy.");
endmodule

/* hw/rtl/mpt_ram.sv */
module mpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* tb/multi_policy_task_picker_checker.sv */
`timescale 1ns / 100ps

module multi_policy_task_picker_checker #(
	parameter int MAX_TASKS = 16
) (
	input  logic             clk,
	input  logic             start,
	input  logic             busy,
	input  mpt_pkg::cmd_t    cmd,
	input  logic             done,
	input  mpt_pkg::result_t result,
	output int               failures,
	output int               pending,
	output int               checked
);
	import mpt_pkg::*;

	int          task_total;
	int          cur_task;
	logic [1:0]  run_state [MAX_TASKS];
	logic [2:0]  pol_tab   [MAX_TASKS];
	logic [15:0] burst_tab [MAX_TASKS];
	logic [15:0] prio_tab  [MAX_TASKS];
	logic [15:0] freq_tab  [MAX_TASKS];
	logic [15:0] dline_tab [MAX_TASKS];
	logic [31:0] runs_tab  [MAX_TASKS];
	result_t     expected_results [$];

	function automatic bit can_run(int i);
		return run_state[i] != ST_SLEEP && run_state[i] != ST_COMPLETED;
	endfunction

	function automatic logic [15:0] sort_key(int i, logic [2:0] pol);
		case (pol)
			POL_SJF:      return burst_tab[i];
			POL_PRIORITY: return prio_tab[i];
			POL_RATE:     return freq_tab[i];
			default:      return dline_tab[i];
		endcase
	endfunction

	function automatic int pick_next(logic [2:0] pol);
		int n;
		int c;
		int last;
		bit found;
		logic [15:0] best_key;
		n = task_total;
		found = 0;
		last = 0;
		best_key = '0;
		if (pol == POL_DEFAULT || pol == POL_FIFO) begin
			c = (cur_task + 1) % n;
			while ((c + 1) % n != cur_task && !can_run(c))
				c = (c + 1) % n;
			return c;
		end else if (pol == POL_LIFO) begin
			c = cur_task;
			forever begin
				c = (c == 0) ? n - 1 : c - 1;
				if (c == cur_task)
					break;
				last = c;
				found = 1;
				if (can_run(c))
					break;
			end
			return found ? last : 0;
		end
		for (int i = 0; i < n; i++) begin
			if (i != cur_task && can_run(i) && (!found || sort_key(i, pol) < best_key)) begin
				found = 1;
				last = i;
				best_key = sort_key(i, pol);
			end
		end
		return found ? last : 0;
	endfunction

	function automatic result_t apply_command(cmd_t c);
		result_t r;
		logic [2:0] pol;
		bit all_done;
		int k;
		r = '0;
		r.status = STS_OK;
		case (c.action)
			ACT_REGISTER: begin
				if (task_total >= MAX_TASKS) begin
					r.status = STS_FULL;
				end else begin
					k = task_total;
					run_state[k] = ST_SUSPENDED;
					runs_tab[k]  = '0;
					pol_tab[k]   = c.has_info ? c.task_policy : POL_DEFAULT;
					burst_tab[k] = c.has_info ? c.exec_burst : '0;
					prio_tab[k]  = c.has_info ? c.priority_value : '0;
					freq_tab[k]  = c.has_info ? c.frequency : '0;
					dline_tab[k] = c.has_info ? c.deadline : '0;
					task_total = k + 1;
				end
			end
			ACT_YIELD: begin
				if (task_total == 0) begin
					r.status = STS_NOTSK;
				end else if (pol_tab[cur_task] != POL_INVALID) begin
					pol = pol_tab[cur_task];
					run_state[cur_task] = ST_COMPLETED;
					all_done = 1;
					for (int i = 0; i < task_total; i++)
						if (run_state[i] != ST_COMPLETED)
							all_done = 0;
					if (all_done)
						for (int i = 0; i < task_total; i++)
							if (run_state[i] != ST_SLEEP)
								run_state[i] = ST_SUSPENDED;
					cur_task = pick_next(pol);
					runs_tab[cur_task]  = runs_tab[cur_task] + 1;
					run_state[cur_task] = ST_RUNNING;
				end
			end
			ACT_RENICE: begin
				if (task_total == 0)
					r.status = STS_NOTSK;
				else
					prio_tab[cur_task] = c.priority_value;
			end
			default: begin
				if (c.task_index >= task_total)
					r.status = STS_NOTSK;
				else
					run_state[c.task_index] = c.sleep_flag ? ST_SLEEP : ST_SUSPENDED;
			end
		endcase
		r.next_task  = cur_task[3:0];
		r.task_count = task_total[4:0];
		if (task_total != 0) begin
			r.current_priority = prio_tab[cur_task];
			r.run_count        = runs_tab[cur_task];
		end
		return r;
	endfunction

	initial begin
		task_total = 0;
		cur_task = 0;
		failures = 0;
		checked = 0;
		for (int i = 0; i < MAX_TASKS; i++)
			run_state[i] = ST_SUSPENDED;
	end

	assign pending = expected_results.size();

	always @(posedge clk) begin
		result_t want;
		int      errs;
		errs = 0;
		if (done) begin
			if (expected_results.size() == 0) begin
				$error("result with no command outstanding: %p", result);
				errs++;
			end else begin
				want = expected_results.pop_front();
				checked <= checked + 1;
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					errs++;
				end
				if (result.next_task !== want.next_task) begin
					$error("next_task: expected %0d, got %0d", want.next_task,
						result.next_task);
					errs++;
				end
				if (result.current_priority !== want.current_priority) begin
					$error("current_priority: expected %0d, got %0d",
						want.current_priority, result.current_priority);
					errs++;
				end
				if (result.run_count !== want.run_count) begin
					$error("run_count: expected %0d, got %0d", want.run_count,
						result.run_count);
					errs++;
				end
				if (result.task_count !== want.task_count) begin
					$error("task_count: expected %0d, got %0d", want.task_count,
						result.task_count);
					errs++;
				end
			end
		end
		if (errs != 0)
			failures <= failures + errs;
		if (start && !busy)
			expected_results.push_back(apply_command(cmd));
	end

endmodule

/* tb/multi_policy_task_picker_top_test.sv */
`timescale 1ns / 100ps

module multi_policy_task_picker_top_test;
	import mpt_pkg::*;

	logic    clk;
	logic    arst_n;
	logic    start;
	cmd_t    cmd;
	logic    busy;
	logic    done;
	result_t result;
	int      failures;
	int      pending;
	int      checked;
	int      action_seen [4];

	multi_policy_task_picker_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	multi_policy_task_picker_checker checker_i (
		.clk      (clk),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.failures (failures),
		.pending  (pending),
		.checked  (checked)
	);

	always #5 clk = ~clk;

	function automatic logic [15:0] pick_key();
		case ($urandom_range(0, 7))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2, 3:    return 16'($urandom_range(0, 7));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic cmd_t make_cmd(logic [1:0] act);
		cmd_t c;
		c = cmd_t'($bits(cmd_t)'({$urandom, $urandom, $urandom}));
		c.action = act;
		c.exec_burst = pick_key();
		c.priority_value = pick_key();
		c.frequency = pick_key();
		c.deadline = pick_key();
		c.task_policy = 3'($urandom_range(0, 6));
		return c;
	endfunction

	// One command transfer: hold start until the block takes it.
	task automatic issue(cmd_t c);
		@(negedge clk);
		cmd = c;
		start = 1'b1;
		do
			@(posedge clk);
		while (busy);
		action_seen[c.action]++;
	endtask

	task automatic pause(int cycles);
		@(negedge clk);
		start = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic issue_entry(logic info, logic [2:0] pol, logic [15:0] b, logic [15:0] p,
		logic [15:0] f, logic [15:0] d);
		cmd_t c;
		c = make_cmd(ACT_REGISTER);
		c.has_info = info;
		c.task_policy = pol;
		c.exec_burst = b;
		c.priority_value = p;
		c.frequency = f;
		c.deadline = d;
		issue(c);
	endtask

	task automatic issue_sleep(logic [3:0] idx, logic flag);
		cmd_t c;
		c = make_cmd(ACT_SLEEP);
		c.task_index = idx;
		c.sleep_flag = flag;
		issue(c);
	endtask

	task automatic issue_renice(logic [15:0] p);
		cmd_t c;
		c = make_cmd(ACT_RENICE);
		c.priority_value = p;
		issue(c);
	endtask

	initial begin
		int burst_len;
		int sent;
		int pick;
		cmd_t c;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		pause(2);

		issue(make_cmd(ACT_YIELD));
		issue_renice(16'hFFFF);
		issue_sleep(4'd0, 1'b1);
		issue_entry(1'b0, POL_DEADLINE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		issue(make_cmd(ACT_YIELD));
		issue_entry(1'b1, POL_FIFO, 16'hFFFF, 16'h0000, 16'h0005, 16'h0005);
		issue_entry(1'b1, POL_LIFO, 16'h0003, 16'hFFFF, 16'h0003, 16'h0003);
		issue_entry(1'b1, POL_SJF, 16'h0000, 16'h0003, 16'hFFFF, 16'h0000);
		issue_entry(1'b1, POL_PRIORITY, 16'h0003, 16'h0003, 16'h0000, 16'hFFFF);
		issue_entry(1'b1, POL_RATE, 16'h0000, 16'h0001, 16'h0000, 16'h0002);
		issue_entry(1'b1, POL_DEADLINE, 16'h0007, 16'h0000, 16'h0001, 16'h0000);
		for (int i = 0; i < 6; i++)
			issue(make_cmd(ACT_YIELD));
		issue_renice(16'h0000);
		issue_sleep(4'd3, 1'b1);
		issue_sleep(4'd15, 1'b0);
		issue(make_cmd(ACT_YIELD));
		issue_sleep(4'd3, 1'b0);
		pause(0);
		wait (pending == 0);

		sent = 0;
		while (sent < 1150) begin
			burst_len = $urandom_range(1, 24);
			for (int i = 0; i < burst_len; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 10) begin
					c = make_cmd(ACT_REGISTER);
					c.has_info = ($urandom_range(0, 4) != 0);
					// An entry of unknown policy freezes the schedule once it is current.
					if ($urandom_range(0, 39) == 0)
						c.task_policy = POL_INVALID;
				end else if (pick < 65) begin
					c = make_cmd(ACT_YIELD);
				end else if (pick < 78) begin
					c = make_cmd(ACT_RENICE);
				end else begin
					c = make_cmd(ACT_SLEEP);
					c.sleep_flag = ($urandom_range(0, 2) == 0);
				end
				issue(c);
				sent++;
			end
			if ($urandom_range(0, 19) == 0) begin
				pause(0);
				wait (pending == 0);
			end else if ($urandom_range(0, 3) != 0) begin
				pause($urandom_range(0, 15));
			end
		end
		pause(0);
		wait (pending == 0);
		repeat (60) @(posedge clk);

		$display("Checked %0d results from %0d registers, %0d yields, %0d renices,",
			checked, action_seen[ACT_REGISTER], action_seen[ACT_YIELD],
			action_seen[ACT_RENICE]);
		$display("and %0d sleep-mark commands, across all seven policies and full table.",
			action_seen[ACT_SLEEP]);
		if (failures == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Run timed out.");
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
